### rtl/imu_vector_level_rotation_core_defines.svh
// assertion macros for the level rotation core
`ifndef IMU_VECTOR_LEVEL_ROTATION_CORE_DEFINES_SVH
`define IMU_VECTOR_LEVEL_ROTATION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vlr assertion failed");
`define VLR_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("vlr implication failed");
`else
`define VLR_ASSERT(lbl, prop)
`define VLR_ASSERT_IMPLY(lbl, cond, prop)
`endif
`endif

### rtl/imu_vlr_pkg.sv
// types, constants and helpers for the level rotation core
`timescale 1ns / 1ps
package imu_vlr_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int LANES = 3;
  localparam int ANG_W = 18;
  localparam int Z_W = 28;
  localparam int CV_W = 33;
  localparam int SC_W = 18;
  localparam int VW = 20;
  localparam int PW = SC_W + VW;
  localparam int SW = PW + 1;

  typedef logic signed [SC_W-1:0] sc_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic fin;
  } smp_t;

  localparam logic signed [CV_W-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [ANG_W-1:0] ANG_HALF = 18'sd18000;
  localparam logic signed [ANG_W-1:0] ANG_FULL = 18'sd36000;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 18'sd9000;
  localparam logic signed [Z_W-1:0] Z_QUARTER = 28'sd36864000;
  localparam logic signed [CV_W-1:0] SC_HALF = 33'sd8192;
  localparam logic signed [SW-1:0] RND_HALF = 39'sd32768;
  localparam logic signed [VW:0] SAT_HI = 21'sd32767;
  localparam logic signed [VW:0] SAT_LO = -21'sd32768;

  // atan(2^-i) in units of 0.01/4096 degree
  function automatic logic signed [Z_W-1:0] atan_val(input logic [3:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      4'd0:    r = 28'sd18432000;
      4'd1:    r = 28'sd10881045;
      4'd2:    r = 28'sd5749245;
      4'd3:    r = 28'sd2918407;
      4'd4:    r = 28'sd1464867;
      4'd5:    r = 28'sd733147;
      4'd6:    r = 28'sd366663;
      4'd7:    r = 28'sd183343;
      4'd8:    r = 28'sd91673;
      4'd9:    r = 28'sd45837;
      4'd10:   r = 28'sd22918;
      4'd11:   r = 28'sd11459;
      4'd12:   r = 28'sd5730;
      4'd13:   r = 28'sd2865;
      4'd14:   r = 28'sd1432;
      4'd15:   r = 28'sd716;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round Q.28 sum to Q8.12, half toward plus infinity
  function automatic vec_t rnd16(input sum_t s);
    sum_t t;
    t = s + RND_HALF;
    t = t >>> 16;
    return t[VW-1:0];
  endfunction

  // negate and clamp to Q4.12
  function automatic logic [15:0] sat_neg(input vec_t v);
    logic signed [VW:0] n;
    logic signed [VW:0] r;
    n = -$signed({v[VW-1], v});
    if (n > SAT_HI) r = SAT_HI;
    else if (n < SAT_LO) r = SAT_LO;
    else r = n;
    return r[15:0];
  endfunction
endpackage

### rtl/imu_vector_level_rotation_core.sv
// Level-frame rotation of an accelerometer sample. A request is taken in every
// clock cycle (busy stays low) and its result appears on the out_ ports with
// out_valid high for one cycle, after passing through 25 register stages:
// the 16-stage unrolled CORDIC that makes sine and cosine of all three angles
// in parallel, plus one prep stage, one sine/cosine rounding stage, a multiply
// stage and an add/round stage for each of roll, pitch and yaw, and the output
// saturation register. The receiver cannot stall the results.
`timescale 1ns / 1ps
`include "imu_vector_level_rotation_core_defines.svh"
module imu_vector_level_rotation_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_yaw_angle,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic        in_final_in,
  output logic        out_valid,
  output logic signed [15:0] out_level_x,
  output logic signed [15:0] out_level_y,
  output logic signed [15:0] out_level_z,
  output logic        out_final_out
);
  import imu_vlr_pkg::*;

  localparam int LATENCY = CORDIC_STEPS + 9;

  // cordic pipeline, index 0 is the prep register
  logic signed [CV_W-1:0] cx_r [CORDIC_STEPS+1][LANES];
  logic signed [CV_W-1:0] cy_r [CORDIC_STEPS+1][LANES];
  logic signed [Z_W-1:0]  cz_r [CORDIC_STEPS+1][LANES];
  logic                   flip_r [CORDIC_STEPS+1][LANES];
  smp_t                   smp_r [CORDIC_STEPS+1];
  logic                   cv_r [CORDIC_STEPS+1];

  logic signed [15:0]     ang [LANES];
  logic signed [Z_W-1:0]  z_nxt [LANES];
  logic                   flip_nxt [LANES];

  assign busy = 1'b0;
  assign ang[0] = in_roll_angle;
  assign ang[1] = in_pitch_angle;
  assign ang[2] = in_yaw_angle;

  // negate, wrap into one turn, fold into [-90, 90] degrees
  always_comb begin
    logic signed [ANG_W-1:0] a;
    for (int l = 0; l < LANES; l++) begin
      a = -$signed({{2{ang[l][15]}}, ang[l]});
      if (a >= ANG_HALF) a = a - ANG_FULL;
      else if (a < -ANG_HALF) a = a + ANG_FULL;
      flip_nxt[l] = 1'b0;
      if (a > ANG_QUARTER) begin
        a = a - ANG_HALF;
        flip_nxt[l] = 1'b1;
      end else if (a < -ANG_QUARTER) begin
        a = a + ANG_HALF;
        flip_nxt[l] = 1'b1;
      end
      z_nxt[l] = {a[15:0], 12'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      cx_r[0][l]   <= CORDIC_X0;
      cy_r[0][l]   <= '0;
      cz_r[0][l]   <= z_nxt[l];
      flip_r[0][l] <= flip_nxt[l];
    end
    smp_r[0] <= '{ax: in_accel_x, ay: in_accel_y, az: in_accel_z, fin: in_final_in};
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CV_W-1:0] x_nxt [LANES];
    logic signed [CV_W-1:0] y_nxt [LANES];
    logic signed [Z_W-1:0]  zs_nxt [LANES];

    always_comb begin
      logic signed [CV_W-1:0] dx;
      logic signed [CV_W-1:0] dy;
      for (int l = 0; l < LANES; l++) begin
        dx = cy_r[i][l] >>> i;
        dy = cx_r[i][l] >>> i;
        if (!cz_r[i][l][Z_W-1]) begin
          x_nxt[l]  = cx_r[i][l] - dx;
          y_nxt[l]  = cy_r[i][l] + dy;
          zs_nxt[l] = cz_r[i][l] - atan_val(4'(i));
        end else begin
          x_nxt[l]  = cx_r[i][l] + dx;
          y_nxt[l]  = cy_r[i][l] - dy;
          zs_nxt[l] = cz_r[i][l] + atan_val(4'(i));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        cx_r[i+1][l]   <= x_nxt[l];
        cy_r[i+1][l]   <= y_nxt[l];
        cz_r[i+1][l]   <= zs_nxt[l];
        flip_r[i+1][l] <= flip_r[i][l];
      end
      smp_r[i+1] <= smp_r[i];
    end
  end

  // sine/cosine rounding to Q.16
  sc_t  sn_r [LANES];
  sc_t  cs_r [LANES];
  sc_t  sn_nxt [LANES];
  sc_t  cs_nxt [LANES];
  smp_t smp_sc_r;
  logic sc_v_r;

  always_comb begin
    logic signed [CV_W-1:0] tc;
    logic signed [CV_W-1:0] ts;
    for (int l = 0; l < LANES; l++) begin
      tc = cx_r[CORDIC_STEPS][l] + SC_HALF;
      ts = cy_r[CORDIC_STEPS][l] + SC_HALF;
      tc = tc >>> 14;
      ts = ts >>> 14;
      cs_nxt[l] = flip_r[CORDIC_STEPS][l] ? -sc_t'(tc[SC_W-1:0]) : sc_t'(tc[SC_W-1:0]);
      sn_nxt[l] = flip_r[CORDIC_STEPS][l] ? -sc_t'(ts[SC_W-1:0]) : sc_t'(ts[SC_W-1:0]);
    end
  end

  // rotation stages
  prod_t r1a_r, r1b_r, r1c_r, r1d_r;
  vec_t  x0_s1_r;
  sc_t   sp_s1_r, cp_s1_r, sy_s1_r, cy_s1_r;
  logic  fin_s1_r;
  vec_t  x1_r, y1_r, z1_r;
  sc_t   sp_s2_r, cp_s2_r, sy_s2_r, cy_s2_r;
  logic  fin_s2_r;
  prod_t p3a_r, p3b_r, p3c_r, p3d_r;
  vec_t  y1_s3_r;
  sc_t   sy_s3_r, cy_s3_r;
  logic  fin_s3_r;
  vec_t  x2_r, y2_r, z2_r;
  sc_t   sy_s4_r, cy_s4_r;
  logic  fin_s4_r;
  prod_t p5a_r, p5b_r, p5c_r, p5d_r;
  vec_t  z2_s5_r;
  logic  fin_s5_r;
  vec_t  x3_r, y3_r, z3_r;
  logic  fin_s6_r;
  logic  s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_v_r;
  logic signed [15:0] lx_r, ly_r, lz_r;
  logic  fo_r;

  vec_t ay_v, az_v;
  assign ay_v = smp_sc_r.ay;
  assign az_v = smp_sc_r.az;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      sc_v_r  <= cv_r[CORDIC_STEPS];
      s1_v_r  <= sc_v_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      out_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      sn_r[l] <= sn_nxt[l];
      cs_r[l] <= cs_nxt[l];
    end
    smp_sc_r <= smp_r[CORDIC_STEPS];
    // roll products
    r1a_r    <= cs_r[0] * ay_v;
    r1b_r    <= sn_r[0] * az_v;
    r1c_r    <= sn_r[0] * ay_v;
    r1d_r    <= cs_r[0] * az_v;
    x0_s1_r  <= vec_t'(smp_sc_r.ax);
    sp_s1_r  <= sn_r[1];
    cp_s1_r  <= cs_r[1];
    sy_s1_r  <= sn_r[2];
    cy_s1_r  <= cs_r[2];
    fin_s1_r <= smp_sc_r.fin;
    // roll sums
    x1_r     <= x0_s1_r;
    y1_r     <= rnd16(sum_t'(r1a_r) - sum_t'(r1b_r));
    z1_r     <= rnd16(sum_t'(r1c_r) + sum_t'(r1d_r));
    sp_s2_r  <= sp_s1_r;
    cp_s2_r  <= cp_s1_r;
    sy_s2_r  <= sy_s1_r;
    cy_s2_r  <= cy_s1_r;
    fin_s2_r <= fin_s1_r;
    // pitch products
    p3a_r    <= cp_s2_r * x1_r;
    p3b_r    <= sp_s2_r * z1_r;
    p3c_r    <= cp_s2_r * z1_r;
    p3d_r    <= sp_s2_r * x1_r;
    y1_s3_r  <= y1_r;
    sy_s3_r  <= sy_s2_r;
    cy_s3_r  <= cy_s2_r;
    fin_s3_r <= fin_s2_r;
    // pitch sums
    x2_r     <= rnd16(sum_t'(p3a_r) + sum_t'(p3b_r));
    y2_r     <= y1_s3_r;
    z2_r     <= rnd16(sum_t'(p3c_r) - sum_t'(p3d_r));
    sy_s4_r  <= sy_s3_r;
    cy_s4_r  <= cy_s3_r;
    fin_s4_r <= fin_s3_r;
    // yaw products
    p5a_r    <= cy_s4_r * x2_r;
    p5b_r    <= sy_s4_r * y2_r;
    p5c_r    <= sy_s4_r * x2_r;
    p5d_r    <= cy_s4_r * y2_r;
    z2_s5_r  <= z2_r;
    fin_s5_r <= fin_s4_r;
    // yaw sums
    x3_r     <= rnd16(sum_t'(p5a_r) - sum_t'(p5b_r));
    y3_r     <= rnd16(sum_t'(p5c_r) + sum_t'(p5d_r));
    z3_r     <= z2_s5_r;
    fin_s6_r <= fin_s5_r;
    // negate and saturate
    lx_r     <= sat_neg(x3_r);
    ly_r     <= sat_neg(y3_r);
    lz_r     <= sat_neg(z3_r);
    fo_r     <= fin_s6_r;
  end

  assign out_valid     = out_v_r;
  assign out_level_x   = lx_r;
  assign out_level_y   = ly_r;
  assign out_level_z   = lz_r;
  assign out_final_out = fo_r;

  `VLR_ASSERT_IMPLY(a_strobe_has_request, out_valid, $past(start, LATENCY))
  `VLR_ASSERT_IMPLY(a_final_follows, out_valid, out_final_out == $past(in_final_in, LATENCY))
  `VLR_ASSERT_IMPLY(a_roll_folded, cv_r[0], (cz_r[0][0] <= Z_QUARTER) && (cz_r[0][0] >= -Z_QUARTER))
  `VLR_ASSERT(a_never_busy, !busy)
endmodule
